/* src/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants for the dispenser cycle controller: register
// indexes, register reset values and the bundles passed between modules.
// ----------------------------------------------------------------------------
package dcc_pkg;

    // register indexes, byte address is 4 * index
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned ADDR_W    = REG_IDX_W + 2;
    localparam int unsigned DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_CYCLE_TICKS    = 2'd1,
        REG_WINDOW_START   = 2'd2,
        REG_MAX_REPEATS    = 2'd3
    } t_reg_idx;

    // register reset values
    localparam logic [7:0]  DEBOUNCE_RST = 8'd96;
    localparam logic [15:0] CYCLE_RST    = 16'd3000;
    localparam logic [15:0] WINDOW_RST   = 16'd750;
    localparam logic [3:0]  MAX_REP_RST  = 4'd5;

    // counter limits
    localparam logic [7:0]  LOW_RUN_MAX  = 8'hFF;
    localparam logic [4:0]  COUNT_FIRST  = 5'd1;

    // configuration bundle
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] cycle_ticks;
        logic [15:0] window_start;
        logic [3:0]  max_repeats;
    } t_cfg;

    // one result beat
    typedef struct packed {
        logic       valve_on;
        logic       repeat_lamp;
        logic [4:0] cycle_number;
    } t_result;

endpackage

/* src/dispenser_cycle_controller_unit.sv */
// ----------------------------------------------------------------------------
// dispenser_cycle_controller_unit
// Debounced press detection and valve cycle control, one tick beat in and
// one result beat out.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+------------------------------
//   tick     | in  | i_in_valid / o_in_stall    | i_sensor_level
//   result   | out | o_out_valid / i_out_stall  | o_valve_on o_repeat_lamp
//            |     |                            | o_cycle_number
//   config   | in  | psel penable pwrite pready | paddr pwdata prdata
//
// One tick beat is taken per clock while o_in_stall is low; its result beat
// is registered. The state update is a single pass of logic.
// o_in_stall rises only when the result register and the skid entry both
// hold beats, i.e. once a tick beat is taken while the result beat is stalled.
// Synchronous active-low reset restores register defaults and controller
// state; no clearing pass.
// ----------------------------------------------------------------------------
module dispenser_cycle_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tick channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_sensor_level,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_valve_on,
    output logic                          o_repeat_lamp,
    output logic [4:0]                    o_cycle_number,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [dcc_pkg::DATA_W-1:0]    pwdata,
    output logic [dcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    dcc_pkg::t_cfg    w_cfg;
    dcc_pkg::t_result w_step_res;
    dcc_pkg::t_result w_out_res;
    logic             w_accept;
    logic             w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // configuration registers
    dcc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // controller state update
    dcc_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_sensor_level (i_sensor_level),
        .i_cfg          (w_cfg),
        .o_result       (w_step_res)
    );

    // result register and skid entry
    dcc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_step_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out_res)
    );

    assign o_valve_on     = w_out_res.valve_on;
    assign o_repeat_lamp  = w_out_res.repeat_lamp;
    assign o_cycle_number = w_out_res.cycle_number;

    // input stalls only while a result beat is waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("tick channel stalled with no result pending");

    // closed valve means the count is back at the first cycle
    a_idle_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valve_on) |-> (o_cycle_number == dcc_pkg::COUNT_FIRST))
        else $error("cycle count not reset while valve closed");

    // a pending repeat exists only during a cycle
    a_lamp_needs_valve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_repeat_lamp) |-> o_valve_on)
        else $error("repeat lamp lit with valve closed");

    // count stays within one to sixteen
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_cycle_number != 5'd0) && (o_cycle_number <= 5'd16)))
        else $error("cycle count out of range");

endmodule

/* src/dcc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dcc_cfg_regs
// APB-style register file holding the four timing registers; writes land on
// the access phase, reads return the zero-extended register value.
// ----------------------------------------------------------------------------
module dcc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [dcc_pkg::DATA_W-1:0]    pwdata,
    output logic [dcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output dcc_pkg::t_cfg                 o_cfg
);

    dcc_pkg::t_cfg    r_cfg;
    dcc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = dcc_pkg::t_reg_idx'(paddr[dcc_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= dcc_pkg::DEBOUNCE_RST;
            r_cfg.cycle_ticks    <= dcc_pkg::CYCLE_RST;
            r_cfg.window_start   <= dcc_pkg::WINDOW_RST;
            r_cfg.max_repeats    <= dcc_pkg::MAX_REP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                dcc_pkg::REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= pwdata[7:0];
                dcc_pkg::REG_CYCLE_TICKS:    r_cfg.cycle_ticks    <= pwdata[15:0];
                dcc_pkg::REG_WINDOW_START:   r_cfg.window_start   <= pwdata[15:0];
                dcc_pkg::REG_MAX_REPEATS:    r_cfg.max_repeats    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            dcc_pkg::REG_DEBOUNCE_TICKS: prdata = {24'd0, r_cfg.debounce_ticks};
            dcc_pkg::REG_CYCLE_TICKS:    prdata = {16'd0, r_cfg.cycle_ticks};
            dcc_pkg::REG_WINDOW_START:   prdata = {16'd0, r_cfg.window_start};
            dcc_pkg::REG_MAX_REPEATS:    prdata = {28'd0, r_cfg.max_repeats};
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* src/dcc_step.sv */
// ----------------------------------------------------------------------------
// dcc_step
// Controller state and its one-tick update: debounce, press handling, cycle
// timer and repeat counting. State advances on every accepted tick beat.
// ----------------------------------------------------------------------------
module dcc_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_sensor_level,
    input  dcc_pkg::t_cfg      i_cfg,
    output dcc_pkg::t_result   o_result
);

    logic [7:0]  r_low_run,   n_low_run;
    logic        r_press_taken, n_press_taken;
    logic        r_dispensing, n_dispensing;
    logic [15:0] r_cycle_timer, n_cycle_timer;
    logic        r_repeat_pending, n_repeat_pending;
    logic [4:0]  r_repeat_count, n_repeat_count;

    logic        w_low;
    logic        w_press;
    logic [7:0]  w_need;
    logic [15:0] w_len;
    logic [16:0] w_next;
    logic        w_pend;

    // next-state logic for one tick
    always_comb begin
        w_low  = !i_sensor_level;
        w_need = (i_cfg.debounce_ticks == 8'd0) ? 8'd1 : i_cfg.debounce_ticks;
        w_len  = (i_cfg.cycle_ticks == 16'd0) ? 16'd1 : i_cfg.cycle_ticks;
        w_next = {1'b0, r_cycle_timer} + 17'd1;

        // debounce, saturating run length
        if (w_low) begin
            n_low_run = (r_low_run == dcc_pkg::LOW_RUN_MAX) ? r_low_run : r_low_run + 8'd1;
        end else begin
            n_low_run = 8'd0;
        end
        w_press       = w_low && !r_press_taken && (n_low_run >= w_need);
        n_press_taken = w_low && (r_press_taken || w_press);

        // press starts a cycle, or requests a repeat once the timer reaches the window start
        n_dispensing  = r_dispensing || w_press;
        n_cycle_timer = r_cycle_timer;
        if (w_press && !r_dispensing) begin
            n_cycle_timer = 16'd0;
        end
        w_pend = r_repeat_pending ||
                 (w_press && r_dispensing && (r_cycle_timer >= i_cfg.window_start));
        n_repeat_pending = w_pend;
        n_repeat_count   = r_repeat_count;

        // timer advance, only for a cycle already running
        if (r_dispensing) begin
            if (w_next >= {1'b0, w_len}) begin
                n_cycle_timer = 16'd0;
                if (!w_pend || (r_repeat_count > {1'b0, i_cfg.max_repeats})) begin
                    n_dispensing   = 1'b0;
                    n_repeat_count = dcc_pkg::COUNT_FIRST;
                end else begin
                    n_repeat_count = r_repeat_count + 5'd1;
                end
                n_repeat_pending = 1'b0;
            end else begin
                n_cycle_timer = w_next[15:0];
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_run        <= 8'd0;
            r_press_taken    <= 1'b0;
            r_dispensing     <= 1'b0;
            r_cycle_timer    <= 16'd0;
            r_repeat_pending <= 1'b0;
            r_repeat_count   <= dcc_pkg::COUNT_FIRST;
        end else if (i_accept) begin
            r_low_run        <= n_low_run;
            r_press_taken    <= n_press_taken;
            r_dispensing     <= n_dispensing;
            r_cycle_timer    <= n_cycle_timer;
            r_repeat_pending <= n_repeat_pending;
            r_repeat_count   <= n_repeat_count;
        end
    end

    // result is the state after the update
    assign o_result.valve_on     = n_dispensing;
    assign o_result.repeat_lamp  = n_repeat_pending;
    assign o_result.cycle_number = n_repeat_count;

endmodule

/* src/dcc_out_skid.sv */
// ----------------------------------------------------------------------------
// dcc_out_skid
// Result register plus one skid entry, so the tick channel can still take one
// tick beat while a result beat waits on a stalled receiver.
// ----------------------------------------------------------------------------
module dcc_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dcc_pkg::t_result   i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output dcc_pkg::t_result   o_data
);

    logic             r_out_valid, r_skd_valid;
    dcc_pkg::t_result r_out, r_skd;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_skd_valid || i_push;
            r_skd_valid <= 1'b0;
        end else if (i_push) begin
            r_skd_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skd_valid ? r_skd : i_data;
        end else if (i_push) begin
            r_skd <= i_data;
        end
    end

    assign o_full  = r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
